>>> rtl/rtfp_pkg.sv
// package for the radar target frame parser
// holds frame layout constants, shared types and the sign-magnitude decode
// no dependencies
`timescale 1ns / 1ps

package rtfp_pkg;

	localparam int FRAME_BYTES  = 30;
	localparam int TARGET_SLOTS = 3;
	localparam int RECORD_BYTES = 8;
	localparam int HEADER_BYTES = 4;
	localparam int FILL_W       = $clog2(FRAME_BYTES + 1);
	localparam int SLOT_W       = $clog2(TARGET_SLOTS);

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] word_t;

	localparam byte_t SYNC_0 = 8'hAA;
	localparam byte_t SYNC_1 = 8'hFF;
	localparam byte_t SYNC_2 = 8'h03;
	localparam byte_t SYNC_3 = 8'h00;
	localparam byte_t TAIL_0 = 8'h55;
	localparam byte_t TAIL_1 = 8'hCC;

	localparam byte_t RUN_MAX       = 8'hFF;
	localparam byte_t ZERO_HOLD_RST = 8'd10;

	typedef struct packed {
		logic               emit;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} slot_rpt_t;

	// bit 15 clear means negative, bits 14..0 the magnitude
	function automatic logic signed [15:0] sm_decode(input word_t w);
		logic [15:0] mag;
		mag = {1'b0, w[14:0]};
		sm_decode = w[15] ? signed'(mag) : signed'(16'd0 - mag);
	endfunction

endpackage

>>> rtl/rtfp_cell.sv
// one byte cell of the frame window shift chain
// depends on rtfp_pkg
`timescale 1ns / 1ps

module rtfp_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  rtfp_pkg::byte_t d,
	output rtfp_pkg::byte_t q
);
	import rtfp_pkg::*;

	byte_t byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (en) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

>>> rtl/rtfp_slot.sv
// one target slot: decodes a record and keeps its all-zero run count
// depends on rtfp_pkg
`timescale 1ns / 1ps

module rtfp_slot (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               hit,
	input  rtfp_pkg::word_t    x_raw,
	input  rtfp_pkg::word_t    y_raw,
	input  rtfp_pkg::word_t    spd_raw,
	input  rtfp_pkg::byte_t    hold,
	output rtfp_pkg::slot_rpt_t rpt
);
	import rtfp_pkg::*;

	byte_t zero_run_q;
	byte_t run_next;
	logic  all_zero;

	// both sign codes of a zero magnitude decode to zero
	assign all_zero = (x_raw[14:0] == 15'd0) && (y_raw[14:0] == 15'd0) &&
		(spd_raw[14:0] == 15'd0);

	always_comb begin
		if (!all_zero) begin
			run_next = '0;
		end else if (zero_run_q == RUN_MAX) begin
			run_next = zero_run_q;
		end else begin
			run_next = zero_run_q + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q <= '0;
		end else if (hit) begin
			zero_run_q <= run_next;
		end
	end

	assign rpt.emit = run_next < hold;
	assign rpt.x    = sm_decode(x_raw);
	assign rpt.y    = sm_decode(y_raw);

endmodule

>>> rtl/radar_target_frame_parser.sv
// top level of the radar target frame parser
// depends on rtfp_pkg, rtfp_cell and rtfp_slot
`timescale 1ns / 1ps

// Takes one report byte per cycle on s_axis and shifts it through a row of 30
// byte cells. A frame is recognised as the closing byte arrives (header
// AA FF 03 00, tail 55 CC, at least 30 bytes since the last frame); its three
// target records are latched as that byte is taken and decoded by three slot
// cells in the next cycle, which also update the per-slot all-zero run counts.
// The items are then registered; up to three leave on m_axis, one per cycle
// while m_axis_tready is high, tlast on the last one of the frame. s_axis
// takes a byte every cycle; it only holds off the byte that could close
// another frame while targets of the previous frame are still waiting on
// m_axis. zero_hold_frames is written on the cfg channel.
module radar_target_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // target_number[1:0], x_position[17:2],
	                                    // y_position[33:18], zero[39:34]
	output logic        m_axis_tlast,   // last_of_frame
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data        // zero_hold_frames[7:0]
);
	import rtfp_pkg::*;

	byte_t                win [FRAME_BYTES];
	logic [FILL_W-1:0]    fill_q;
	byte_t                zero_hold_q;
	logic                 in_acc;
	logic                 out_acc;
	logic                 hit;

	logic                 hit_s1;
	word_t                xr_s1 [TARGET_SLOTS];
	word_t                yr_s1 [TARGET_SLOTS];
	word_t                sr_s1 [TARGET_SLOTS];
	slot_rpt_t            rpt [TARGET_SLOTS];

	logic [TARGET_SLOTS-1:0] pend_q;
	logic signed [15:0]      ox_q [TARGET_SLOTS];
	logic signed [15:0]      oy_q [TARGET_SLOTS];
	logic [SLOT_W-1:0]       sel;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// byte chain, newest byte enters at the top cell
	for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
		byte_t d;
		if (i == FRAME_BYTES - 1) begin : g_top
			assign d = s_axis_tdata;
		end else begin : g_mid
			assign d = win[i+1];
		end
		rtfp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (in_acc),
			.d      (d),
			.q      (win[i])
		);
	end

	// window as it will be after this byte, checked one cell ahead
	assign hit = in_acc && (fill_q >= FILL_W'(FRAME_BYTES - 1)) &&
		(win[1] == SYNC_0) && (win[2] == SYNC_1) &&
		(win[3] == SYNC_2) && (win[4] == SYNC_3) &&
		(win[FRAME_BYTES-1] == TAIL_0) && (s_axis_tdata == TAIL_1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (in_acc) begin
			if (hit) begin
				fill_q <= '0;
			end else if (fill_q != FILL_W'(FRAME_BYTES)) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_hold_q <= ZERO_HOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			zero_hold_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else begin
			hit_s1 <= hit;
		end
	end

	// records start one cell above their place in the shifted window
	for (genvar t = 0; t < TARGET_SLOTS; t++) begin : g_slot
		localparam int B = HEADER_BYTES + 1 + t * RECORD_BYTES;

		always_ff @(posedge clk) begin
			if (hit) begin
				xr_s1[t] <= {win[B+1], win[B]};
				yr_s1[t] <= {win[B+3], win[B+2]};
				sr_s1[t] <= {win[B+5], win[B+4]};
			end
		end

		rtfp_slot u_slot (
			.clk     (clk),
			.arst_n  (arst_n),
			.hit     (hit_s1),
			.x_raw   (xr_s1[t]),
			.y_raw   (yr_s1[t]),
			.spd_raw (sr_s1[t]),
			.hold    (zero_hold_q),
			.rpt     (rpt[t])
		);

		always_ff @(posedge clk) begin
			if (hit_s1) begin
				ox_q[t] <= rpt[t].x;
				oy_q[t] <= rpt[t].y;
			end
		end
	end

	always_comb begin
		sel = SLOT_W'(TARGET_SLOTS - 1);
		for (int k = TARGET_SLOTS - 1; k >= 0; k--) begin
			if (pend_q[k]) begin
				sel = SLOT_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (hit_s1) begin
			for (int k = 0; k < TARGET_SLOTS; k++) begin
				pend_q[k] <= rpt[k].emit;
			end
		end else if (out_acc) begin
			pend_q <= pend_q & ~(TARGET_SLOTS'(1) << sel);
		end
	end

	// a closing byte waits only while the previous frame still drains
	assign s_axis_tready = (fill_q < FILL_W'(FRAME_BYTES - 1)) ||
		(!hit_s1 && (pend_q == '0));

	assign m_axis_tvalid = |pend_q;
	assign m_axis_tlast  = (pend_q & (pend_q - TARGET_SLOTS'(1))) == '0;
	assign m_axis_tdata  = {6'd0, oy_q[sel], ox_q[sel], sel + 2'd1};

`ifndef SYNTHESIS
	a_hit_empty: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> (pend_q == '0) && !hit_s1)
		else $error("frame closed while targets still pending");

	a_fill_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		hit |=> (fill_q == '0))
		else $error("window count not cleared after frame");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s1 |-> !m_axis_tvalid)
		else $error("target buffer loaded while still holding items");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (fill_q < FILL_W'(FRAME_BYTES)))
		else $error("targets still pending after a full window");
`endif

endmodule
